FILE: rtl/pbve_pkg.sv
// Shared types and constants for the posting block varbyte encoder.
// Used by pbve_ctrl, pbve_dp and posting_block_varbyte_encoder.
`timescale 1ns / 1ps
package pbve_pkg;

  localparam int BLOCK_LEN_DEF = 128;
  localparam int DOC_W         = 32;
  localparam int CNT_W         = 10;
  localparam int GROUP_W       = 7;

  typedef enum logic [1:0] {
    KIND_GAP  = 2'd0,
    KIND_FREQ = 2'd1,
    KIND_SUM  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DOC_W-1:0] doc_id;
    logic [DOC_W-1:0] frequency;
    logic             end_of_list;
  } in_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       code_byte;
    logic [DOC_W-1:0] block_last_doc;
    logic [CNT_W-1:0] doc_bytes;
    logic [CNT_W-1:0] freq_bytes;
    logic             last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;
    logic  emit;
    kind_t phase;
  } pbve_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;
    logic close;
    logic out_free;
  } pbve_sts_t;

endpackage

FILE: rtl/posting_block_varbyte_encoder.sv
// Posting encoder top level: joins the controller and the datapath.
// Depends on pbve_pkg, pbve_ctrl and pbve_dp.
//
// Use: one posting request (doc_id, frequency, end_of_list) on the in
// channel gives 2 to 11 result requests on the out channel: the gap
// bytes, then the frequency bytes, low 7-bit group first with bit 7 set on
// a value's final byte, then a block summary when the block reaches
// BLOCK_LEN postings or end_of_list is set. last marks the final result.
// in_ready is high only between postings; one posting is coded at a time.
// The accept loads the posting into the shared 7-bit group shifter, which
// then gives one result per cycle while out_ready stays high; the first
// result is offered from the output register after the gap state emits it.
// Results sit in an output register, so the last one may still wait
// while the next posting is taken.
// A low out_ready holds the current result and stalls the sequencer.
// Reset clears the block position, previous id and byte counts; the next
// posting opens a new block with its id sent raw.
`timescale 1ns / 1ps
module posting_block_varbyte_encoder #(
  parameter int BLOCK_LEN = pbve_pkg::BLOCK_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbve_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbve_pkg::out_t out_data
);
  import pbve_pkg::*;

  pbve_cmd_t cmd;
  pbve_sts_t sts;

  pbve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbve_dp #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/pbve_ctrl.sv
// Sequencer for the posting encoder: gap bytes, frequency bytes, summary.
// Depends on pbve_pkg; drives pbve_dp through pbve_cmd_t.
`timescale 1ns / 1ps
module pbve_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbve_pkg::pbve_sts_t sts,
  output pbve_pkg::pbve_cmd_t cmd
);
  import pbve_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GAP,
    S_FREQ,
    S_SUM
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.phase = KIND_GAP;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_GAP: begin
        cmd.emit  = sts.out_free;
        cmd.phase = KIND_GAP;
      end
      S_FREQ: begin
        cmd.emit  = sts.out_free;
        cmd.phase = KIND_FREQ;
      end
      S_SUM: begin
        cmd.emit  = sts.out_free;
        cmd.phase = KIND_SUM;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_GAP;
        S_GAP:  if (sts.out_free && !sts.more) state <= S_FREQ;
        S_FREQ: begin
          if (sts.out_free && !sts.more) state <= sts.close ? S_SUM : S_IDLE;
        end
        S_SUM:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // a load starts the gap phase; a new posting is only taken once the previous one has emitted everything
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_GAP)
    else $error("pbve_ctrl: load did not start gap phase");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FREQ && sts.out_free && !sts.more && !sts.close) |=> in_ready)
    else $error("pbve_ctrl: not ready after final frequency byte");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.emit))
    else $error("pbve_ctrl: load and emit together");

endmodule

FILE: rtl/pbve_dp.sv
// Datapath: gap and frequency code, 7-bit group shifter, block counters,
// output register. Depends on pbve_pkg; commanded by pbve_ctrl.
`timescale 1ns / 1ps
module pbve_dp #(
  parameter int BLOCK_LEN = pbve_pkg::BLOCK_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pbve_pkg::in_t       in_data,
  input  pbve_pkg::pbve_cmd_t cmd,
  output pbve_pkg::pbve_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output pbve_pkg::out_t      out_data
);
  import pbve_pkg::*;

  localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  logic [POS_W-1:0] pos;
  logic [DOC_W-1:0] prev_doc;
  logic [CNT_W-1:0] doc_cnt;
  logic [CNT_W-1:0] freq_cnt;

  logic [DOC_W-1:0] val;      // value being coded, shifted 7 bits per byte
  logic [DOC_W-1:0] fcode;
  logic [DOC_W-1:0] doc_q;
  logic             eol_q;

  logic [DOC_W-1:0] gap;
  logic [7:0]       code;
  logic             more;
  logic             close;
  logic             fin;      // final frequency byte of this posting

  always_comb begin
    gap   = (pos == '0) ? in_data.doc_id : in_data.doc_id - prev_doc;
    more  = |val[DOC_W-1:GROUP_W];
    code  = {~more, val[GROUP_W-1:0]};
    close = eol_q || (pos == POS_W'(BLOCK_LEN - 1));
    fin   = cmd.emit && (cmd.phase == KIND_FREQ) && !more;
    sts.more     = more;
    sts.close    = close;
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val   <= gap;
      fcode <= (in_data.frequency == '0) ? '0 : in_data.frequency - DOC_W'(1);
      doc_q <= in_data.doc_id;
      eol_q <= in_data.end_of_list;
    end else if (cmd.emit && cmd.phase != KIND_SUM) begin
      if (more) val <= val >> GROUP_W;
      else if (cmd.phase == KIND_GAP) val <= fcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      prev_doc <= '0;
      doc_cnt  <= '0;
      freq_cnt <= '0;
    end else if (cmd.emit) begin
      unique case (cmd.phase)
        KIND_GAP: if (doc_cnt != '1) doc_cnt <= doc_cnt + CNT_W'(1);
        KIND_FREQ: begin
          if (freq_cnt != '1) freq_cnt <= freq_cnt + CNT_W'(1);
          if (fin) begin
            prev_doc <= doc_q;
            pos      <= close ? '0 : pos + POS_W'(1);
          end
        end
        KIND_SUM: begin
          doc_cnt  <= '0;
          freq_cnt <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.kind <= cmd.phase;
      if (cmd.phase == KIND_SUM) begin
        out_data.code_byte      <= '0;
        out_data.block_last_doc <= doc_q;
        out_data.doc_bytes      <= doc_cnt;
        out_data.freq_bytes     <= freq_cnt;
        out_data.last           <= 1'b1;
      end else begin
        out_data.code_byte      <= code;
        out_data.block_last_doc <= '0;
        out_data.doc_bytes      <= '0;
        out_data.freq_bytes     <= '0;
        out_data.last           <= fin && !close;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("pbve_dp: result overwritten before taken");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_SUM) |-> out_data.last)
    else $error("pbve_dp: summary not marked last");

  assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(BLOCK_LEN - 1))
    else $error("pbve_dp: block position past block length");

endmodule
